@@ hw/rtl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, codes and types of the RPN stack evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIT_W    = 10;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  localparam logic [LIT_W-1:0] MAX_LIT_RESET = 10'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FEW_OPS   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_ILLEGAL   = 3'd4,
    ST_NOT_ONE   = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_RD_B,
    FSM_RD_A,
    FSM_EXEC,
    FSM_DIV,
    FSM_CHK,
    FSM_FIN,
    FSM_RD0,
    FSM_EMIT
  } fsm_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic status_e flag(status_e cur, status_e e);
    return (cur == ST_OK) ? e : cur;
  endfunction

endpackage

@@ hw/rtl/rpn_in_if.sv @@
// ----------------------------------------------------------------------------
// rpn_in_if
// Character request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ hw/rtl/rpn_out_if.sv @@
// ----------------------------------------------------------------------------
// rpn_out_if
// Result request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [2:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ hw/rtl/rpn_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rpn_cfg_if
// Configuration write channel (max_literal).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpn_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/rpn_div.sv @@
// ----------------------------------------------------------------------------
// rpn_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rpn_pkg::DATA_W-1:0] dividend_i,
  input  logic [rpn_pkg::DATA_W-1:0] divisor_i,
  output rpn_pkg::div_stat_t        stat_o,
  output logic [rpn_pkg::DATA_W-1:0] quotient_o
);
  import rpn_pkg::*;

  localparam int unsigned STEP_W = $clog2(DATA_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W:0]   rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic [DATA_W:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      quo_d  = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      dsr_d  = divisor_i[DATA_W-1] ? (~divisor_i + 1'b1) : divisor_i;
      rem_d  = '0;
      step_d = '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = rem_sh - {1'b0, dsr_q};
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dsr_q  <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

@@ hw/rtl/rpn_stack_evaluator.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// RPN expression evaluator over a stack memory with a registered read port.
// ----------------------------------------------------------------------------
// Digits, spaces and other characters take FSM_IDLE only; + - * go through
// RD_B, RD_A, EXEC and CHK; divide adds DIV (bit-serial divider, 32 steps
// plus done). The last character adds FIN, RD0 and EMIT (final push, read of
// entry 0, result load). Throughput: one character at a time; a result waits
// in an output register. Reset (async, active low) clears control state and
// sets max_literal to 10; the stack memory is not cleared.
`timescale 1ns / 1ps

module rpn_stack_evaluator (
  input  logic          clk_i,
  input  logic          rst_ni,
  rpn_in_if.sink        in_i,
  rpn_out_if.source     out_o,
  rpn_cfg_if.sink       cfg_i
);
  import rpn_pkg::*;

  logic [DATA_W-1:0] mem_q [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  fsm_e              state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LIT_W-1:0]  acc_q, acc_d;
  logic              lit_q, lit_d;
  status_e           err_q, err_d;
  logic              last_q, last_d;
  logic [CHAR_W-1:0] op_q, op_d;
  logic [LIT_W-1:0]  max_q;
  logic [DATA_W-1:0] b_q, b_d;
  logic signed [63:0] res_q, res_d;

  logic              ov_q, ov_d;
  logic [DATA_W-1:0] val_q, val_d;
  status_e           sts_q, sts_d;

  logic              in_acc;
  logic              div_start;
  div_stat_t         div_stat;
  logic [DATA_W-1:0] div_quo;

  logic [13:0]       acc_ext;
  logic              is_digit, is_op, full, out_free;
  logic signed [DATA_W-1:0] a_s, b_s;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rdata_q),
    .divisor_i  (b_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign in_i.ready  = (state_q == FSM_IDLE);
  assign in_acc      = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !ov_q || out_o.ready;

  assign is_digit = (in_i.character >= CH_ZERO) && (in_i.character <= CH_NINE);
  assign is_op    = (in_i.character == CH_PLUS) || (in_i.character == CH_MINUS) ||
                    (in_i.character == CH_MUL)  || (in_i.character == CH_DIV);
  assign acc_ext  = ({4'b0, acc_q & {LIT_W{lit_q}}} * 14'd10) +
                    14'(in_i.character - CH_ZERO);
  assign full     = (cnt_q >= CNT_W'(STACK_DEPTH));
  assign cnt_m1   = cnt_q - 1'b1;
  assign cnt_m2   = cnt_q - CNT_W'(2);
  assign a_s      = $signed(rdata_q);
  assign b_s      = $signed(b_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          if (err_q == ST_OK && is_op && !lit_q && cnt_q >= CNT_W'(2)) begin
            state_d = FSM_RD_B;
          end else if (in_i.last) begin
            state_d = FSM_FIN;
          end
        end
      end
      FSM_RD_B: state_d = FSM_RD_A;
      FSM_RD_A: state_d = FSM_EXEC;
      FSM_EXEC: begin
        if (op_q != CH_DIV) begin
          state_d = FSM_CHK;
        end else if (b_q == '0 || (rdata_q == {1'b1, {(DATA_W-1){1'b0}}} && b_q == '1)) begin
          state_d = last_q ? FSM_FIN : FSM_IDLE;
        end else begin
          state_d = FSM_DIV;
        end
      end
      FSM_DIV:  if (div_stat.done) state_d = FSM_CHK;
      FSM_CHK:  state_d = last_q ? FSM_FIN : FSM_IDLE;
      FSM_FIN:  state_d = FSM_RD0;
      FSM_RD0:  state_d = FSM_EMIT;
      FSM_EMIT: if (out_free) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    lit_d     = lit_q;
    err_d     = err_q;
    last_d    = last_q;
    op_d      = op_q;
    b_d       = b_q;
    res_d     = res_q;
    ov_d      = ov_q & ~out_o.ready;
    val_d     = val_q;
    sts_d     = sts_q;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = cnt_q[ADDR_W-1:0];
    wr_data   = {{(DATA_W-LIT_W){1'b0}}, acc_q};
    div_start = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          last_d = in_i.last;
          op_d   = in_i.character;
          if (err_q == ST_OK) begin
            priority if (is_digit) begin
              lit_d = 1'b1;
              acc_d = acc_ext[LIT_W-1:0];
              if (acc_ext > {4'b0, max_q}) err_d = ST_ILLEGAL;
            end else if (in_i.character == CH_SPACE) begin
              if (lit_q) begin
                lit_d = 1'b0;
                acc_d = '0;
                if (full) begin
                  err_d = ST_FULL;
                end else begin
                  wr_en = 1'b1;
                  cnt_d = cnt_q + 1'b1;
                end
              end
            end else if (is_op) begin
              if (lit_q)                    err_d = ST_ILLEGAL;
              else if (cnt_q < CNT_W'(2))   err_d = ST_FEW_OPS;
            end else if (!(in_i.character == CH_NUL && in_i.last)) begin
              err_d = ST_ILLEGAL;
            end
          end
        end
      end
      FSM_RD_B: rd_addr = cnt_m1[ADDR_W-1:0];
      FSM_RD_A: begin
        b_d     = rdata_q;
        rd_addr = cnt_m2[ADDR_W-1:0];
      end
      FSM_EXEC: begin
        cnt_d = cnt_m2;
        unique case (op_q)
          CH_PLUS:  res_d = 64'(a_s) + 64'(b_s);
          CH_MINUS: res_d = 64'(a_s) - 64'(b_s);
          CH_MUL:   res_d = a_s * b_s;
          default: begin
            if (b_q == '0) begin
              err_d = ST_DIV_ZERO;
            end else if (rdata_q == {1'b1, {(DATA_W-1){1'b0}}} && b_q == '1) begin
              err_d = ST_OVERFLOW;
            end else begin
              div_start = 1'b1;
            end
          end
        endcase
      end
      FSM_DIV: begin
        if (div_stat.done) res_d = 64'($signed(div_quo));
      end
      FSM_CHK: begin
        if (!(res_q[63:31] == '0 || res_q[63:31] == '1)) begin
          err_d = ST_OVERFLOW;
        end else if (full) begin
          err_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_data = res_q[DATA_W-1:0];
          cnt_d   = cnt_q + 1'b1;
        end
      end
      FSM_FIN: begin
        if (err_q == ST_OK) begin
          if (lit_q) begin
            if (full) begin
              err_d = ST_FULL;
            end else begin
              wr_en = 1'b1;
              cnt_d = cnt_q + 1'b1;
              if (cnt_q != '0) err_d = ST_NOT_ONE;
            end
          end else if (cnt_q != CNT_W'(1)) begin
            err_d = ST_NOT_ONE;
          end
        end
      end
      FSM_RD0: rd_addr = '0;
      FSM_EMIT: begin
        if (out_free) begin
          ov_d  = 1'b1;
          val_d = (err_q == ST_OK) ? rdata_q : '0;
          sts_d = err_q;
          cnt_d = '0;
          acc_d = '0;
          lit_d = 1'b0;
          err_d = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      lit_q   <= 1'b0;
      err_q   <= ST_OK;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
      max_q   <= MAX_LIT_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      lit_q   <= lit_d;
      err_q   <= err_d;
      last_q  <= last_d;
      ov_q    <= ov_d;
      if (cfg_i.valid) max_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    b_q   <= b_d;
    res_q <= res_d;
    val_q <= val_d;
    sts_q <= sts_d;
  end

  // stack memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rdata_q <= mem_q[rd_addr];
  end

  assign out_o.valid  = ov_q;
  assign out_o.value  = val_q;
  assign out_o.status = sts_q;

endmodule

@@ hw/rtl/rpn_checker.sv @@
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level assertions for the RPN evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_value_i,
  input logic [2:0]  out_status_i
);
  import rpn_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
    $stable(out_status_i))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_value_i == 32'd0)
    else $error("nonzero value with error status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i != 3'd7)
    else $error("undefined status code");

  a_in_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a finishing sequence");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_value_i  (out_o.value),
  .out_status_i (out_o.status)
);

@@ test/rpn_stack_evaluator_tb.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_tb
// Self-checking bench: directed expressions, then random RPN streams checked
// against a behavioral evaluator, under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_stack_evaluator_tb;
  import rpn_pkg::*;

  typedef struct packed {
    logic [7:0]  ch;
    logic        lst;
    logic        chk;
    logic [31:0] val;
    status_e     st;
  } row_t;

  typedef struct packed {
    logic [31:0] val;
    status_e     st;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rpn_in_if  in_ch ();
  rpn_out_if out_ch ();
  rpn_cfg_if cfg_ch ();

  rpn_stack_evaluator uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always #1 clk_i = ~clk_i;

  // evaluator state
  logic [31:0] ev_stack [STACK_DEPTH];
  int unsigned ev_cnt;
  logic [31:0] ev_lit;
  logic        ev_lit_on;
  status_e     ev_err;
  logic [9:0]  ev_max;

  res_t        results_q [$];
  logic        typed_q [$];
  res_t        typed_val_q [$];
  int          errors = 0;
  int          n_sent = 0;
  int          src_idle = 13;
  int          snk_idle = 69;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
  endtask

  function automatic void ev_flag(status_e e);
    if (ev_err == ST_OK) ev_err = e;
  endfunction

  function automatic void ev_push(logic [31:0] v);
    if (ev_cnt >= STACK_DEPTH) begin
      ev_flag(ST_FULL);
    end else begin
      ev_stack[ev_cnt] = v;
      ev_cnt++;
    end
  endfunction

  function automatic void ev_op(logic [7:0] c);
    longint a, b, r;
    if (ev_cnt < 2) begin
      ev_flag(ST_FEW_OPS);
      return;
    end
    b = longint'($signed(ev_stack[ev_cnt-1]));
    a = longint'($signed(ev_stack[ev_cnt-2]));
    ev_cnt -= 2;
    case (c)
      CH_PLUS:  r = a + b;
      CH_MINUS: r = a - b;
      CH_MUL:   r = a * b;
      default: begin
        if (b == 0) begin
          ev_flag(ST_DIV_ZERO);
          return;
        end
        r = a / b;
      end
    endcase
    if (r > 64'sd2147483647 || r < -64'sd2147483648) ev_flag(ST_OVERFLOW);
    else ev_push(r[31:0]);
  endfunction

  // returns 1 and fills res when the character closes an expression
  function automatic bit evaluate_char(logic [7:0] c, logic lst, output res_t res);
    res = '0;
    if (ev_err == ST_OK) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!ev_lit_on) begin
          ev_lit_on = 1'b1;
          ev_lit = '0;
        end
        ev_lit = ev_lit * 32'd10 + 32'(c - CH_ZERO);
        if (ev_lit > 32'(ev_max)) ev_flag(ST_ILLEGAL);
      end else if (c == CH_SPACE) begin
        if (ev_lit_on) begin
          ev_push(ev_lit);
          ev_lit_on = 1'b0;
          ev_lit = '0;
        end
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV) begin
        if (ev_lit_on) ev_flag(ST_ILLEGAL);
        else ev_op(c);
      end else if (!(c == CH_NUL && lst)) begin
        ev_flag(ST_ILLEGAL);
      end
    end
    if (!lst) return 0;
    if (ev_err == ST_OK && ev_lit_on) ev_push(ev_lit);
    if (ev_err == ST_OK && ev_cnt != 1) ev_flag(ST_NOT_ONE);
    res.val = (ev_err == ST_OK) ? ev_stack[0] : '0;
    res.st  = ev_err;
    ev_cnt = 0;
    ev_lit = '0;
    ev_lit_on = 1'b0;
    ev_err = ST_OK;
    return 1;
  endfunction

  // valid stays high after the request is taken; idling or a pause drops it
  task automatic send_char(input logic [7:0] c, input logic lst, input logic chk = 1'b0,
                           input res_t typed = '0);
    res_t r;
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= c;
    in_ch.last      <= lst;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    n_sent++;
    if (evaluate_char(c, lst, r)) begin
      results_q.push_back(r);
      typed_q.push_back(chk);
      typed_val_q.push_back(typed);
    end
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // receiver
  always @(posedge clk_i) begin
    res_t  exp;
    logic  typed;
    res_t  tv;
    if (out_ch.valid && out_ch.ready) begin
      if (results_q.size() == 0) begin
        report("unexpected result", out_ch.value, 32'd0);
      end else begin
        exp   = results_q.pop_front();
        typed = typed_q.pop_front();
        tv    = typed_val_q.pop_front();
        if (typed) exp = tv;
        if (out_ch.value !== exp.val) report("value", out_ch.value, exp.val);
        if (out_ch.status !== exp.st) report("status", 32'(out_ch.status), 32'(exp.st));
      end
    end
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic write_max(input logic [9:0] v);
    in_ch.valid <= 1'b0;
    while (results_q.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    ev_max = v;
  endtask

  function automatic string rand_lit();
    int unsigned hi;
    hi = ($urandom_range(9) == 0) ? ev_max + 3 : ev_max;
    return $sformatf("%0d", $urandom_range(hi));
  endfunction

  // well-formed-ish random expression, usually valid
  task automatic rand_expr();
    int unsigned depth, n;
    string s, ops;
    ops = "+-*/";
    s = "";
    depth = 0;
    n = $urandom_range(12, 1);
    for (int i = 0; i < n; i++) begin
      if (depth >= 2 && $urandom_range(1)) begin
        s = {s, string'(ops[$urandom_range(3)])};
        depth--;
      end else begin
        s = {s, rand_lit()};
        depth++;
      end
      s = {s, " "};
      if ($urandom_range(7) == 0) s = {s, " "};
    end
    while (depth > 1) begin
      s = {s, string'(ops[$urandom_range(3)]), " "};
      depth--;
    end
    if ($urandom_range(1)) s = s.substr(0, s.len() - 2);
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(60) == 0)
        send_char(8'($urandom_range(255)), 1'b0);
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic rand_noise();
    int n;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++)
      send_char((i == n - 1 && $urandom_range(3) == 0) ? CH_NUL : 8'($urandom_range(255)),
                i == n - 1);
  endtask

  task automatic run_random(input int items);
    int stop;
    stop = n_sent + items;
    while (n_sent < stop) begin
      case ($urandom_range(9))
        0:       rand_noise();
        1: begin
          // push to a full stack
          for (int i = 0; i < STACK_DEPTH + 1; i++) begin
            send_char("1", 1'b0);
            send_char(CH_SPACE, 1'b0);
          end
          send_char(CH_PLUS, 1'b1);
        end
        default: rand_expr();
      endcase
    end
  endtask

  row_t directed [] = '{
    '{CH_NUL,   1, 1, 32'd0, ST_NOT_ONE},
    '{"9",      1, 1, 32'd9, ST_OK},
    '{"0",      1, 1, 32'd0, ST_OK},
    '{"1",      0, 1, 32'd0, ST_ILLEGAL},
    '{"1",      1, 1, 32'd0, ST_ILLEGAL},
    '{"+",      1, 1, 32'd0, ST_FEW_OPS},
    '{"7",      0, 0, 32'd0, ST_OK},
    '{" ",      0, 0, 32'd0, ST_OK},
    '{" ",      0, 0, 32'd0, ST_OK},
    '{"3",      0, 0, 32'd0, ST_OK},
    '{" ",      0, 0, 32'd0, ST_OK},
    '{"-",      1, 0, 32'd0, ST_OK},
    '{"5",      0, 1, 32'd0, ST_ILLEGAL},
    '{"*",      1, 1, 32'd0, ST_ILLEGAL},
    '{"4",      0, 0, 32'd0, ST_OK},
    '{" ",      0, 0, 32'd0, ST_OK},
    '{"0",      0, 0, 32'd0, ST_OK},
    '{" ",      0, 0, 32'd0, ST_OK},
    '{"/",      1, 1, 32'd0, ST_DIV_ZERO},
    '{8'h09,    1, 1, 32'd0, ST_ILLEGAL},
    '{CH_NUL,   0, 0, 32'd0, ST_OK},
    '{8'hFF,    1, 1, 32'd0, ST_ILLEGAL},
    '{"8",      0, 0, 32'd0, ST_OK},
    '{" ",      0, 0, 32'd0, ST_OK},
    '{"2",      0, 0, 32'd0, ST_OK}
  };

  initial begin
    res_t tv;
    in_ch.valid     = 1'b0;
    in_ch.character = '0;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    ev_cnt = 0; ev_lit = '0; ev_lit_on = 1'b0; ev_err = ST_OK; ev_max = MAX_LIT_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      tv.val = directed[i].val;
      tv.st  = directed[i].st;
      send_char(directed[i].ch, directed[i].lst, directed[i].chk, tv);
    end
    send_char("/", 1'b1);

    // overflow cases, minimum over minus one, divide truncation
    write_max(10'd1023);
    send_str("1000 1000 * 1000 * 1000 * 1 -");
    send_str("0 1000 - 1000 * 1000 * 2 * 1000 * 1 -");
    send_str({"0 1000 1000 * 1000 * 2 * 147 1000 * 1000 * + 483 1000 * + 647 + - ",
              "1 - 0 1 - /"});
    send_str("0 7 - 2 /");
    send_str("1023");
    send_str("1024");

    write_max(10'd0);
    run_random(200);
    write_max(10'($urandom_range(1023)));
    run_random(300);
    write_max(10'd1023);
    src_idle = 69; snk_idle = 13;
    run_random(400);
    write_max(10'd9);
    src_idle = 0; snk_idle = 0;
    run_random(400);

    in_ch.valid <= 1'b0;
    while (results_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("rpn_stack_evaluator regression: pass");
    else $display("rpn_stack_evaluator regression: fail");
    $finish;
  end

  initial begin
    #20000000;
    $display("rpn_stack_evaluator regression: fail");
    $finish;
  end

endmodule
